// ===== hdl/adsr_envelope_generator_core_macros.svh =====
// Assertion macros shared by the envelope generator RTL.
// Used by the divider and the top level; define ASSERT_OFF to drop them.
`ifndef ADSR_ENVELOPE_GENERATOR_CORE_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset
`define ADSR_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset
`define ADSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ADSR_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define ADSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/adsr_pkg.sv =====
// Shared types and constants of the ADSR envelope generator.
// No dependencies; imported by the divider, the top level and the bench.
`timescale 1ns / 1ps
package adsr_pkg;

  // Field and register widths
  localparam int OP_W          = 2;
  localparam int LEN_W         = 24;
  localparam int LVL_W         = 16;
  localparam int PROD_W        = LEN_W + LVL_W;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 24;
  localparam int CNT_W         = $clog2(LVL_W + 1);
  localparam int TIME_BITS_DEF = 32;
  localparam int FRACTION_BITS = 15;

  // Levels at or below this are forced to zero
  localparam int                 THRESH_INT = (1 << FRACTION_BITS) / 10000;
  localparam logic [LVL_W-1:0]   THRESH     = LVL_W'(THRESH_INT);

  // Register reset values
  localparam logic [LEN_W-1:0] ATTACK_RST  = LEN_W'(4410);
  localparam logic [LEN_W-1:0] DECAY_RST   = LEN_W'(2205);
  localparam logic [LEN_W-1:0] RELEASE_RST = LEN_W'(8820);
  localparam logic [LVL_W-1:0] PEAK_RST    = LVL_W'(32768);
  localparam logic [LVL_W-1:0] SUSTAIN_RST = LVL_W'(26214);

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2
  } op_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_ATTACK  = 3'd0,
    CFG_DECAY   = 3'd1,
    CFG_RELEASE = 3'd2,
    CFG_PEAK    = 3'd3,
    CFG_SUSTAIN = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } state_t;

  // How the quotient combines with the base level
  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_CONST,
    MODE_ADD,
    MODE_SUB
  } mode_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] num;
    logic [LEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [LVL_W-1:0] quot;
  } div_stat_t;

endpackage

// ===== hdl/adsr_div.sv =====
// Serial restoring divider: one quotient bit per cycle.
// Depends on adsr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "adsr_envelope_generator_core_macros.svh"
module adsr_div import adsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  div_req_t  req,
  output div_stat_t stat
);

  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LVL_W-1:0] lo_r, lo_nxt;
  logic [LEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W:0]   shifted;
  logic [LEN_W:0]   diff;
  logic             ge;
  logic             busy;

  assign busy = (cnt_r != '0);

  // Compare-subtract step on the partial remainder
  always_comb begin
    shifted = {rem_r, lo_r[LVL_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
    rem_nxt = ge ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
    lo_nxt  = {lo_r[LVL_W-2:0], ge};
    cnt_nxt = cnt_r - CNT_W'(1);
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= CNT_W'(LVL_W);
    end else if (busy) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Remainder and numerator/quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num[PROD_W-1:LVL_W];
      lo_r  <= req.num[LVL_W-1:0];
      den_r <= req.den;
    end else if (busy) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
    end
  end

  assign stat.busy = busy;
  assign stat.quot = lo_r;

  `ADSR_ASSERT(a_start_idle, clk, rst_n, req.start, !busy, "divider started while busy")
  `ADSR_ASSERT(a_rem_below, clk, rst_n, busy, rem_r < den_r, "partial remainder not below divisor")
  `ADSR_ASSERT_NEXT(a_start_cnt, clk, rst_n, req.start, cnt_r == CNT_W'(LVL_W), "step count not loaded")

endmodule

// ===== hdl/adsr_envelope_generator_core.sv =====
// Sequence from an accepted transaction to out_tvalid on an attack, decay or release ramp:
// setup, multiply, load, 16-step serial divide, finish; a held or zero level goes from setup
// straight to finish. One item at a time; the next transaction is taken the cycle after the
// result is loaded, and finish waits while the output register holds a result not yet taken.
// Reset (rst_n, synchronous, active low): gate off, note times 0, registers to their defaults.
// Depends on adsr_pkg, adsr_div and the assertion macro header.
`timescale 1ns / 1ps
`include "adsr_envelope_generator_core_macros.svh"
module adsr_envelope_generator_core import adsr_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((TIME_BITS+7)/8)*8-1:0]     in_tdata,   // [TIME_BITS-1:0] sample_time
  input  logic [OP_W-1:0]                    in_tuser,   // [1:0] op
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [LVL_W-1:0]                   out_tdata,  // [15:0] amplitude
  // Configuration writes
  input  logic                               cfg_wr_en,
  input  logic [CFG_AW-1:0]                  cfg_addr,
  input  logic [CFG_DW-1:0]                  cfg_wdata
);

  localparam int EW = (TIME_BITS > LEN_W) ? TIME_BITS : LEN_W;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]     attack_r, decay_r, release_r;
  logic [LVL_W-1:0]     peak_r, sustain_r;
  logic                 gate_r;
  logic [TIME_BITS-1:0] on_time_r, off_time_r, time_r;

  mode_t                mode_r, mode_nxt;
  logic [LEN_W-1:0]     x_r, x_nxt;
  logic [LVL_W-1:0]     m_r, m_nxt;
  logic [LEN_W-1:0]     den_r, den_nxt;
  logic [LVL_W-1:0]     base_r, base_nxt;
  logic [PROD_W-1:0]    prod_r;

  logic                 out_tvalid_r;
  logic [LVL_W-1:0]     out_data_r;

  logic                 in_fire;
  logic                 out_load;
  logic [LVL_W-1:0]     amp_raw, amp_fin;
  div_req_t             div_req;
  div_stat_t            div_stat;

  logic [LEN_W-1:0]     len_a, len_d, len_r;
  logic [TIME_BITS-1:0] life, rel;
  logic [EW-1:0]        life_e, rel_e, k_e, a_e, d_e, r_e;

  assign in_fire = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= ATTACK_RST;
      decay_r   <= DECAY_RST;
      release_r <= RELEASE_RST;
      peak_r    <= PEAK_RST;
      sustain_r <= SUSTAIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_ATTACK:  attack_r  <= cfg_wdata[LEN_W-1:0];
        CFG_DECAY:   decay_r   <= cfg_wdata[LEN_W-1:0];
        CFG_RELEASE: release_r <= cfg_wdata[LEN_W-1:0];
        CFG_PEAK:    peak_r    <= cfg_wdata[LVL_W-1:0];
        CFG_SUSTAIN: sustain_r <= cfg_wdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Apply note events on acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r     <= 1'b0;
      on_time_r  <= '0;
      off_time_r <= '0;
    end else if (in_fire) begin
      case (in_tuser)
        OP_NOTE_ON: begin
          gate_r    <= 1'b1;
          on_time_r <= in_tdata[TIME_BITS-1:0];
        end
        OP_NOTE_OFF: begin
          gate_r     <= 1'b0;
          off_time_r <= in_tdata[TIME_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  // Hold the sample time of the item in flight
  always_ff @(posedge clk) begin
    if (in_fire) begin
      time_r <= in_tdata[TIME_BITS-1:0];
    end
  end

  // Segment selection: pick numerator factors, divisor and base level
  always_comb begin
    len_a  = (attack_r == '0) ? LEN_W'(1) : attack_r;
    len_d  = (decay_r == '0) ? LEN_W'(1) : decay_r;
    len_r  = (release_r == '0) ? LEN_W'(1) : release_r;
    life   = time_r - on_time_r;
    rel    = time_r - off_time_r;
    life_e = EW'(life);
    rel_e  = EW'(rel);
    a_e    = EW'(len_a);
    d_e    = EW'(len_d);
    r_e    = EW'(len_r);
    k_e    = life_e - a_e;

    mode_nxt = MODE_ZERO;
    x_nxt    = '0;
    m_nxt    = '0;
    den_nxt  = LEN_W'(1);
    base_nxt = '0;
    if (gate_r) begin
      if (life_e <= a_e) begin
        mode_nxt = MODE_ADD;
        x_nxt    = life_e[LEN_W-1:0];
        m_nxt    = peak_r;
        den_nxt  = len_a;
      end else if (k_e <= d_e) begin
        x_nxt    = k_e[LEN_W-1:0];
        den_nxt  = len_d;
        base_nxt = peak_r;
        if (sustain_r <= peak_r) begin
          mode_nxt = MODE_SUB;
          m_nxt    = peak_r - sustain_r;
        end else begin
          mode_nxt = MODE_ADD;
          m_nxt    = sustain_r - peak_r;
        end
      end else begin
        mode_nxt = MODE_CONST;
        base_nxt = sustain_r;
      end
    end else if (rel_e < r_e) begin
      mode_nxt = MODE_SUB;
      x_nxt    = rel_e[LEN_W-1:0];
      m_nxt    = sustain_r;
      den_nxt  = len_r;
      base_nxt = sustain_r;
    end
  end

  // Capture the segment operands
  always_ff @(posedge clk) begin
    if (state_r == ST_SETUP) begin
      mode_r <= mode_nxt;
      x_r    <= x_nxt;
      m_r    <= m_nxt;
      den_r  <= den_nxt;
      base_r <= base_nxt;
    end
  end

  // Numerator product
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(x_r) * PROD_W'(m_r);
    end
  end

  // Shared divider
  assign div_req.start = (state_r == ST_LOAD);
  assign div_req.num   = prod_r;
  assign div_req.den   = den_r;

  adsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat)
  );

  // Combine quotient with base and squelch tiny levels
  always_comb begin
    case (mode_r)
      MODE_CONST: amp_raw = base_r;
      MODE_ADD:   amp_raw = base_r + div_stat.quot;
      MODE_SUB:   amp_raw = base_r - div_stat.quot;
      default:    amp_raw = '0;
    endcase
    amp_fin = (amp_raw <= THRESH) ? '0 : amp_raw;
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_SETUP;
      ST_SETUP: begin
        if (mode_nxt == MODE_ADD || mode_nxt == MODE_SUB) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_MUL:    state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_DIV;
      ST_DIV:    if (!div_stat.busy) state_nxt = ST_FINISH;
      ST_FINISH: if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_FINISH: out_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  // Output register: hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= amp_fin;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  `ADSR_ASSERT(a_no_tiny, clk, rst_n, out_tvalid_r, out_data_r == '0 || out_data_r > THRESH, "level at or below threshold not squelched")
  `ADSR_ASSERT(a_sub_range, clk, rst_n, state_r == ST_FINISH && mode_r == MODE_SUB, div_stat.quot <= base_r, "falling ramp quotient exceeds base level")
  `ADSR_ASSERT(a_div_done, clk, rst_n, state_r == ST_FINISH || state_r == ST_IDLE, !div_stat.busy, "divider busy outside divide phase")
  `ADSR_ASSERT_NEXT(a_accept_setup, clk, rst_n, in_fire, state_r == ST_SETUP, "accepted item did not enter setup")
  `ADSR_ASSERT_NEXT(a_load_valid, clk, rst_n, out_load, out_tvalid_r, "loaded result not presented")

endmodule

// ===== bench/adsr_envelope_generator_core_test.sv =====
// Self-checking bench for the linear ADSR envelope core: a directed opening, then
// note phrases with random content under several register settings.
// Depends on adsr_pkg and the adsr_envelope_generator_core RTL.
`timescale 1ns / 1ps
module adsr_envelope_generator_core_test;
  import adsr_pkg::*;

  // Op code outside the enum; the core treats it as a tick
  localparam logic [OP_W-1:0]   OP_SPARE   = 2'd3;
  // Register index with no register behind it
  localparam logic [CFG_AW-1:0] CFG_UNUSED = 3'd7;
  localparam int                IDLE_PCT   = 21;
  localparam int                HOLD_LEN   = 400;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [31:0]     stamp;
  } note_event_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata   = '0;   // [31:0] sample_time
  logic [OP_W-1:0]   in_tuser   = '0;   // [1:0] op
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [LVL_W-1:0]  out_tdata;         // [15:0] amplitude
  logic              cfg_wr_en  = 1'b0;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  logic [CFG_DW-1:0] cfg_wdata  = '0;

  // Stimulus and scoreboard storage
  note_event_t      pending_events[$];
  logic [LVL_W-1:0] levels_due[$];
  int               mismatches = 0;
  logic [31:0]      cursor     = '0;
  bit               calm       = 1'b0;
  bit               in_taken   = 1'b0;
  int               hold_asks  = 0;
  int               hold_seen  = 0;
  int               hold_left  = 0;

  // Envelope state and register copy kept by the bench
  logic [LEN_W-1:0] atk_len  = ATTACK_RST;
  logic [LEN_W-1:0] dec_len  = DECAY_RST;
  logic [LEN_W-1:0] rel_len  = RELEASE_RST;
  logic [LVL_W-1:0] peak_lvl = PEAK_RST;
  logic [LVL_W-1:0] sus_lvl  = SUSTAIN_RST;
  bit               gate_open = 1'b0;
  logic [31:0]      on_stamp  = '0;
  logic [31:0]      off_stamp = '0;

  adsr_envelope_generator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Mirror a register write; unknown indexes are dropped
  task automatic apply_setting(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    case (idx)
      CFG_ATTACK:  atk_len  = val[LEN_W-1:0];
      CFG_DECAY:   dec_len  = val[LEN_W-1:0];
      CFG_RELEASE: rel_len  = val[LEN_W-1:0];
      CFG_PEAK:    peak_lvl = val[LVL_W-1:0];
      CFG_SUSTAIN: sus_lvl  = val[LVL_W-1:0];
      default: ;
    endcase
  endtask

  // Apply the note event, then return the envelope level at its sample time
  function automatic logic [LVL_W-1:0] step_envelope(input logic [OP_W-1:0] op,
                                                     input logic [31:0] t);
    logic [31:0] since;
    logic [63:0] life, a_len, d_len, r_len, pk, su, k, amp;
    if (op == OP_NOTE_ON) begin
      on_stamp  = t;
      gate_open = 1'b1;
    end else if (op == OP_NOTE_OFF) begin
      off_stamp = t;
      gate_open = 1'b0;
    end
    pk    = {48'd0, peak_lvl};
    su    = {48'd0, sus_lvl};
    a_len = (atk_len == 0) ? 64'd1 : {40'd0, atk_len};
    d_len = (dec_len == 0) ? 64'd1 : {40'd0, dec_len};
    r_len = (rel_len == 0) ? 64'd1 : {40'd0, rel_len};
    if (gate_open) begin
      since = t - on_stamp;
      life  = {32'd0, since};
      if (life <= a_len) begin
        amp = (life * pk) / a_len;
      end else if (life - a_len <= d_len) begin
        // Decay toward sustain, truncated toward the peak
        k = life - a_len;
        if (su <= pk) amp = pk - (k * (pk - su)) / d_len;
        else          amp = pk + (k * (su - pk)) / d_len;
      end else begin
        amp = su;
      end
    end else begin
      // Release always starts from sustain, measured from the note-off time
      since = t - off_stamp;
      life  = {32'd0, since};
      if (life >= r_len) amp = 64'd0;
      else               amp = su - (life * su) / r_len;
    end
    if (amp <= THRESH) amp = 64'd0;
    return amp[LVL_W-1:0];
  endfunction

  // Feed queued events onto the input channel; hold each until its transaction
  always @(negedge clk) begin : feed_events
    bit          go;
    note_event_t ev;
    go = in_tvalid;
    if (in_tvalid && in_taken) go = 1'b0;
    if (!go && rst_n && pending_events.size() != 0 &&
        (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
      ev = pending_events.pop_front();
      in_tdata <= ev.stamp;
      in_tuser <= ev.op;
      go = 1'b1;
    end
    in_tvalid <= go;
  end

  // Drive the result ready, with random gaps and a requested long hold-off
  always @(negedge clk) begin : drain_levels
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Sample writes and transactions; predict on input, check on output
  always @(posedge clk) begin : watch_ports
    logic [LVL_W-1:0] want;
    if (!rst_n) begin
      in_taken  = 1'b0;
      gate_open = 1'b0;
      on_stamp  = '0;
      off_stamp = '0;
    end else begin
      if (cfg_wr_en) apply_setting(cfg_addr, cfg_wdata);
      in_taken = in_tvalid && in_tready;
      if (in_taken) levels_due.push_back(step_envelope(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (levels_due.size() == 0) begin
          flag_mismatch($sformatf("amplitude %0d with no event waiting", out_tdata));
        end else begin
          want = levels_due.pop_front();
          if (out_tdata !== want)
            flag_mismatch($sformatf("amplitude %0d, expected %0d", out_tdata, want));
        end
      end
    end
  end

  task automatic push_event(input logic [OP_W-1:0] op, input logic [31:0] t);
    note_event_t ev;
    ev.op    = op;
    ev.stamp = t;
    pending_events.push_back(ev);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every event is taken and every amplitude is back, then let the core settle
  task automatic wait_idle();
    while (pending_events.size() != 0 || in_tvalid || levels_due.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // One note: on, ticks walking across the ramps, an off, more ticks, a little noise
  task automatic add_phrase(input logic [31:0] span, input int count);
    int          i, off_at, roll;
    logic [31:0] step_max;
    step_max = span / 8 + 1;
    if (count < 6) count = 6;
    off_at = $urandom_range(2, count - 2);
    if ($urandom_range(0, 9) == 0) cursor = $urandom;
    push_event(OP_NOTE_ON, cursor);
    for (i = 1; i < count; i++) begin
      cursor += $urandom_range(0, step_max);
      roll = $urandom_range(0, 99);
      if (i == off_at)   push_event(OP_NOTE_OFF, cursor);
      else if (roll < 8) push_event(OP_W'($urandom_range(0, 3)), $urandom);
      else if (roll < 12) push_event(OP_W'($urandom_range(0, 3)), cursor);
      else               push_event(OP_TICK, cursor);
    end
  endtask

  // Write all five registers, then queue about n events of phrases
  task automatic run_phase(input logic [LEN_W-1:0] a, d, r, input logic [LVL_W-1:0] p, s,
                           input int n);
    logic [7:0]  junk;
    logic [31:0] span;
    int          left, cnt;
    write_reg(CFG_ATTACK, a);
    write_reg(CFG_DECAY, d);
    junk = 8'($urandom_range(0, 255));
    write_reg(CFG_PEAK, {junk, p});
    write_reg(CFG_RELEASE, r);
    junk = 8'($urandom_range(0, 255));
    write_reg(CFG_SUSTAIN, {junk, s});
    span = {8'd0, a} + {8'd0, d} + {8'd0, r};
    left = n;
    while (left > 0) begin
      cnt = $urandom_range(6, 30);
      add_phrase(span, cnt);
      left -= cnt;
    end
  endtask

  // Pick a random setting: mostly short ramps, sometimes full-range values
  task automatic run_random_phase(input int n);
    logic [LEN_W-1:0] a, d, r;
    logic [LVL_W-1:0] p, s;
    a = LEN_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 256)
                                          : $urandom_range(0, 24'hFFFFFF));
    d = LEN_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 256)
                                          : $urandom_range(0, 24'hFFFFFF));
    r = LEN_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 256)
                                          : $urandom_range(0, 24'hFFFFFF));
    p = LVL_W'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 32768)
                                          : $urandom_range(0, 16'hFFFF));
    s = LVL_W'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 32768)
                                          : $urandom_range(0, 16'hFFFF));
    run_phase(a, d, r, p, s, n);
  endtask

  // Test sequence
  initial begin : stimulus
    int spin;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Release before any note, threshold, unused op, time extremes
    push_event(OP_TICK, 32'd0);
    push_event(OP_TICK, 32'd100);
    push_event(OP_SPARE, 32'd8819);
    push_event(OP_TICK, 32'hFFFF_FFFF);
    // Attack, peak, decay, end of decay, hold
    push_event(OP_NOTE_ON, 32'd1000);
    push_event(OP_TICK, 32'd1001);
    push_event(OP_TICK, 32'd3205);
    push_event(OP_TICK, 32'd5410);
    push_event(OP_TICK, 32'd5411);
    push_event(OP_TICK, 32'd6500);
    push_event(OP_TICK, 32'd7615);
    push_event(OP_TICK, 32'd7616);
    push_event(OP_TICK, 32'd500000);
    // Release from sustain down through the threshold to zero
    push_event(OP_NOTE_OFF, 32'd600000);
    push_event(OP_TICK, 32'd604410);
    push_event(OP_TICK, 32'd608818);
    push_event(OP_TICK, 32'd608819);
    push_event(OP_TICK, 32'd608820);
    // Retrigger and release at one time, then a note across the time wrap
    push_event(OP_NOTE_ON, 32'd608900);
    push_event(OP_NOTE_OFF, 32'd608900);
    push_event(OP_NOTE_ON, 32'hFFFF_FF00);
    push_event(OP_TICK, 32'h0000_0100);
    push_event(OP_SPARE, 32'h0000_0200);
    wait_idle();

    // Short ramps, with a long result hold-off while events keep coming
    run_phase(LEN_W'($urandom_range(1, 64)), LEN_W'($urandom_range(1, 64)),
              LEN_W'($urandom_range(1, 64)), 16'd32768, LVL_W'($urandom_range(0, 32768)),
              150);
    hold_asks++;
    wait_idle();
    // Zero lengths and zero levels
    run_phase('0, '0, '0, '0, '0, 60);
    wait_idle();
    // Unit lengths, sustain equal to peak
    run_phase(24'd1, 24'd1, 24'd1, 16'd32768, 16'd32768, 60);
    wait_idle();
    // Longest ramps, zero sustain
    run_phase(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'd32768, 16'd0, 100);
    wait_idle();
    // Sustain above peak: decay rises
    run_phase(LEN_W'($urandom_range(1, 100)), LEN_W'($urandom_range(1, 100)),
              LEN_W'($urandom_range(1, 100)), 16'd1000, 16'd30000, 100);
    wait_idle();
    // Levels beyond 1.0, plus a write to an index with no register
    write_reg(CFG_UNUSED, CFG_DW'($urandom_range(0, 24'hFFFFFF)));
    run_phase(LEN_W'($urandom_range(1, 40)), LEN_W'($urandom_range(1, 40)),
              LEN_W'($urandom_range(1, 40)), 16'hFFFF, 16'd40000, 100);
    wait_idle();

    // No idling on either side
    calm = 1'b1;
    run_random_phase(150);
    wait_idle();
    calm = 1'b0;

    // Random settings; one phase pauses the sender halfway until all results return
    for (spin = 0; spin < 6; spin++) begin
      run_random_phase(75);
      if (spin == 2) wait_idle();
      while (pending_events.size() > 40) @(posedge clk);
      add_phrase(32'd400, 50);
      wait_idle();
    end

    // Drain, allow for late or extra results, then judge
    while (pending_events.size() != 0 || in_tvalid) @(posedge clk);
    for (spin = 0; spin < 2000 && levels_due.size() != 0; spin++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (levels_due.size() != 0)
      flag_mismatch($sformatf("%0d amplitudes never arrived", levels_due.size()));
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #(64'd12 * 64'd1000000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
